/* hw/rtl/tcdb_pkg.sv */
// shared types and constants for the text console display buffer
package tcdb_pkg;

    localparam int CELL_W = 16;

    localparam logic [7:0] BLANK_CHAR   = 8'h20;
    localparam logic [7:0] CH_NEWLINE   = 8'h0A;
    localparam logic [7:0] CH_RETURN    = 8'h0D;
    localparam logic [7:0] CH_BACKSPACE = 8'h08;
    localparam logic [7:0] CH_DELETE    = 8'h7F;

    localparam logic [7:0] RESET_ATTR = 8'd7;
    localparam logic [6:0] RESET_COLS = 7'd80;
    localparam logic [4:0] RESET_ROWS = 5'd25;

    typedef enum logic [1:0] {
        OP_WRITE = 2'd0,
        OP_SET   = 2'd1,
        OP_CLEAR = 2'd2,
        OP_READ  = 2'd3
    } op_t;

    typedef enum logic [1:0] {
        REG_COLS = 2'd0,
        REG_ROWS = 2'd1,
        REG_ATTR = 2'd2
    } reg_idx_t;

endpackage

/* hw/rtl/tcdb_cell_ram.sv */
// screen cell memory, one write port and one registered read port
module tcdb_cell_ram
    import tcdb_pkg::*;
#(
    parameter int DEPTH = 2000,
    parameter int AW    = 11
) (
    input  logic              aclk,
    input  logic              wr_en,
    input  logic [AW-1:0]     wr_addr,
    input  logic [CELL_W-1:0] wr_data,
    input  logic              rd_en,
    input  logic [AW-1:0]     rd_addr,
    output logic [CELL_W-1:0] rd_data
);

    logic [CELL_W-1:0] mem [DEPTH];
    logic [CELL_W-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

/* hw/rtl/text_console_display_buffer_core.sv */
// text console display buffer: cursor, scroll and clear control around the cell memory
//
//  channel  | ports          | item
//  ---------+----------------+--------------------------------------------------
//  input    | s_t*           | op in tuser, char/column/row in tdata
//  result   | m_t*           | read cell, cursor, scroll count, range error
//  config   | apb (p*)       | columns_in_use, rows_in_use, fill_attribute
//
// write char (no scroll), set cursor and read cell pass through the execute
// state, which drives the cell memory port, then the result stage, which
// already takes the next item. a scroll adds a memory walk that copies rows up
// through the single read/write port pair and then blanks the bottom row (with
// one active row only the blank pass runs); a clear adds a sweep over every cell.
// after reset a clearing pass over every cell fills the memory with blanks;
// s_tready stays low meanwhile, config writes are taken. a stalled result holds
// the block in the result stage with s_tready low until m_tready.
module text_console_display_buffer_core
    import tcdb_pkg::*;
#(
    parameter int MAX_COLUMNS = 80,
    parameter int MAX_ROWS    = 25
) (
    input  logic        aclk,
    input  logic        aresetn,
    // input item
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [23:0] s_tdata,   // char_code[7:0], target_column[14:8], target_row[19:15]
    input  logic [1:0]  s_tuser,   // op[1:0]
    // result item
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [95:0] m_tdata,   // cell_char[7:0], cell_attr[15:8], cur_column[22:16],
                                   // cur_row[27:23], scrolls_total[91:28], range_error[92]
    // config port
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    localparam int CELLS = MAX_COLUMNS * MAX_ROWS;
    localparam int AW    = (CELLS > 1) ? $clog2(CELLS) : 1;
    localparam int AW1   = $clog2(CELLS + 1);   // also holds CELLS and MAX_COLUMNS

    typedef enum logic [6:0] {
        ST_INIT  = 7'b0000001,
        ST_IDLE  = 7'b0000010,
        ST_EXEC  = 7'b0000100,
        ST_COPY  = 7'b0001000,
        ST_BLANK = 7'b0010000,
        ST_CLEAR = 7'b0100000,
        ST_DONE  = 7'b1000000
    } state_t;

    state_t state_reg, state_next;

    // config registers
    logic [6:0] cfg_cols_reg;
    logic [4:0] cfg_rows_reg;
    logic [7:0] cfg_attr_reg;

    // captured item
    op_t        op_reg;
    logic [7:0] ch_reg;
    logic [6:0] tc_reg;
    logic [4:0] tr_reg;

    // console state
    logic [6:0]  cur_col_reg;
    logic [4:0]  cur_row_reg;
    logic [63:0] scroll_cnt_reg;

    // sweep engine
    logic [AW1-1:0] sw_addr_reg;    // copy read address / blank and clear write address
    logic [AW1-1:0] row_base_reg;   // base of the row being copied
    logic [6:0]     sw_col_reg;
    logic [4:0]     sw_row_reg;
    logic           cp_pend_reg;    // a copy read is in flight, write it back next cycle
    logic [AW1-1:0] cp_waddr_reg;

    // result bookkeeping
    logic res_err_reg;
    logic res_rd_reg;

    // output register
    logic        m_tvalid_reg;
    logic [95:0] m_tdata_reg;

    // memory ports
    logic              mem_wr_en;
    logic [AW1-1:0]    mem_wr_addr;
    logic [CELL_W-1:0] mem_wr_data;
    logic              mem_rd_en;
    logic [AW1-1:0]    mem_rd_addr;
    logic [CELL_W-1:0] mem_rd_data;

    // ------------------------------------------------------------------
    // handshakes
    // ------------------------------------------------------------------
    logic out_free;
    logic s_fire;
    logic cfg_wr;

    assign out_free = !m_tvalid_reg || m_tready;
    assign s_tready = (state_reg == ST_IDLE) || ((state_reg == ST_DONE) && out_free);
    assign s_fire   = s_tvalid && s_tready;
    assign cfg_wr   = psel && penable && pwrite;
    assign pready   = 1'b1;

    // ------------------------------------------------------------------
    // active geometry, zero acts as one and large values saturate
    // ------------------------------------------------------------------
    logic [6:0] act_cols;
    logic [4:0] act_rows;

    always_comb begin
        if (cfg_cols_reg == 7'd0) begin
            act_cols = 7'd1;
        end else if (int'(cfg_cols_reg) > MAX_COLUMNS) begin
            act_cols = 7'(MAX_COLUMNS);
        end else begin
            act_cols = cfg_cols_reg;
        end
        if (cfg_rows_reg == 5'd0) begin
            act_rows = 5'd1;
        end else if (int'(cfg_rows_reg) > MAX_ROWS) begin
            act_rows = 5'(MAX_ROWS);
        end else begin
            act_rows = cfg_rows_reg;
        end
    end

    // ------------------------------------------------------------------
    // execute: decode the item against the saturated cursor
    // ------------------------------------------------------------------
    logic [6:0]     sat_col, col_inc, nxt_col, acc_col;
    logic [4:0]     sat_row, row_inc, nxt_row, acc_row;
    logic           ex_wr, ex_rd, ex_err, ex_scroll, ex_clear;
    logic [7:0]     ex_char;
    logic [AW1-1:0] acc_addr;

    always_comb begin
        sat_col   = (cur_col_reg >= act_cols) ? act_cols - 7'd1 : cur_col_reg;
        sat_row   = (cur_row_reg >= act_rows) ? act_rows - 5'd1 : cur_row_reg;
        col_inc   = sat_col + 7'd1;
        row_inc   = sat_row + 5'd1;
        nxt_col   = sat_col;
        nxt_row   = sat_row;
        acc_col   = sat_col;
        acc_row   = sat_row;
        ex_wr     = 1'b0;
        ex_rd     = 1'b0;
        ex_err    = 1'b0;
        ex_scroll = 1'b0;
        ex_clear  = 1'b0;
        ex_char   = ch_reg;
        case (op_reg)
            OP_WRITE: begin
                unique case (ch_reg) inside
                    CH_NEWLINE: begin
                        nxt_col = 7'd0;
                        if (row_inc >= act_rows) begin
                            ex_scroll = 1'b1;
                        end else begin
                            nxt_row = row_inc;
                        end
                    end
                    CH_RETURN: begin
                        nxt_col = 7'd0;
                    end
                    CH_BACKSPACE, CH_DELETE: begin
                        ex_char = BLANK_CHAR;
                        if (sat_col == 7'd0) begin
                            // erase at home does nothing
                            if (sat_row != 5'd0) begin
                                nxt_row = sat_row - 5'd1;
                                nxt_col = act_cols - 7'd1;
                                acc_row = sat_row - 5'd1;
                                acc_col = act_cols - 7'd1;
                                ex_wr   = 1'b1;
                            end
                        end else begin
                            nxt_col = sat_col - 7'd1;
                            acc_col = sat_col - 7'd1;
                            ex_wr   = 1'b1;
                        end
                    end
                    default: begin
                        ex_wr = 1'b1;
                        if (col_inc >= act_cols) begin
                            nxt_col = 7'd0;
                            if (row_inc >= act_rows) begin
                                ex_scroll = 1'b1;
                            end else begin
                                nxt_row = row_inc;
                            end
                        end else begin
                            nxt_col = col_inc;
                        end
                    end
                endcase
            end
            OP_SET: begin
                if (tc_reg >= act_cols || tr_reg >= act_rows) begin
                    ex_err = 1'b1;
                end else begin
                    nxt_col = tc_reg;
                    nxt_row = tr_reg;
                end
            end
            OP_CLEAR: begin
                ex_clear = 1'b1;
                nxt_col  = 7'd0;
                nxt_row  = 5'd0;
            end
            default: begin
                if (tc_reg >= act_cols || tr_reg >= act_rows) begin
                    ex_err = 1'b1;
                end else begin
                    ex_rd   = 1'b1;
                    acc_col = tc_reg;
                    acc_row = tr_reg;
                end
            end
        endcase
        // scrolling homes the column and parks on the bottom row
        if (ex_scroll) begin
            nxt_col = 7'd0;
            nxt_row = act_rows - 5'd1;
        end
    end

    // one constant-coefficient multiply serves both the write and the read address
    assign acc_addr = AW1'(acc_row) * AW1'(MAX_COLUMNS) + AW1'(acc_col);

    // ------------------------------------------------------------------
    // memory port steering
    // ------------------------------------------------------------------
    always_comb begin
        mem_wr_en   = 1'b0;
        mem_wr_addr = sw_addr_reg;
        mem_wr_data = {cfg_attr_reg, BLANK_CHAR};
        mem_rd_en   = 1'b0;
        mem_rd_addr = acc_addr;
        unique case (state_reg)
            ST_INIT: begin
                mem_wr_en   = 1'b1;
                mem_wr_data = {RESET_ATTR, BLANK_CHAR};
            end
            ST_EXEC: begin
                mem_wr_en   = ex_wr;
                mem_wr_addr = acc_addr;
                mem_wr_data = {cfg_attr_reg, ex_char};
                mem_rd_en   = ex_rd;
            end
            ST_COPY: begin
                mem_rd_en   = 1'b1;
                mem_rd_addr = sw_addr_reg;
                mem_wr_en   = cp_pend_reg;
                mem_wr_addr = cp_waddr_reg;
                mem_wr_data = mem_rd_data;
            end
            ST_BLANK: begin
                // the last copy write-back goes before the blank row starts
                mem_wr_en = 1'b1;
                if (cp_pend_reg) begin
                    mem_wr_addr = cp_waddr_reg;
                    mem_wr_data = mem_rd_data;
                end
            end
            ST_CLEAR: begin
                mem_wr_en = 1'b1;
            end
            ST_IDLE, ST_DONE: begin
            end
            default: begin
            end
        endcase
    end

    tcdb_cell_ram #(
        .DEPTH (CELLS),
        .AW    (AW)
    ) u_cell_ram (
        .aclk    (aclk),
        .wr_en   (mem_wr_en),
        .wr_addr (mem_wr_addr[AW-1:0]),
        .wr_data (mem_wr_data),
        .rd_en   (mem_rd_en),
        .rd_addr (mem_rd_addr[AW-1:0]),
        .rd_data (mem_rd_data)
    );

    // ------------------------------------------------------------------
    // sequencer
    // ------------------------------------------------------------------
    logic copy_row_end, copy_last, blank_last, sweep_last;

    assign copy_row_end = (sw_col_reg == act_cols - 7'd1);
    assign copy_last    = copy_row_end && (sw_row_reg == act_rows - 5'd1);
    assign blank_last   = !cp_pend_reg && (sw_col_reg == act_cols - 7'd1);
    assign sweep_last   = (sw_addr_reg == AW1'(CELLS - 1));

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_INIT: begin
                if (sweep_last) begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (s_fire) begin
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC: begin
                if (ex_clear) begin
                    state_next = ST_CLEAR;
                end else if (ex_scroll) begin
                    state_next = (act_rows > 5'd1) ? ST_COPY : ST_BLANK;
                end else begin
                    state_next = ST_DONE;
                end
            end
            ST_COPY: begin
                if (copy_last) begin
                    state_next = ST_BLANK;
                end
            end
            ST_BLANK: begin
                if (blank_last) begin
                    state_next = ST_DONE;
                end
            end
            ST_CLEAR: begin
                if (sweep_last) begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE: begin
                if (out_free) begin
                    state_next = s_fire ? ST_EXEC : ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_INIT;
            sw_addr_reg    <= '0;
            cp_pend_reg    <= 1'b0;
            cur_col_reg    <= 7'd0;
            cur_row_reg    <= 5'd0;
            scroll_cnt_reg <= 64'd0;
        end else begin
            state_reg   <= state_next;
            cp_pend_reg <= 1'b0;
            unique case (state_reg)
                ST_INIT, ST_CLEAR: begin
                    sw_addr_reg <= sw_addr_reg + AW1'(1);
                end
                ST_EXEC: begin
                    cur_col_reg <= nxt_col;
                    cur_row_reg <= nxt_row;
                    if (ex_scroll) begin
                        scroll_cnt_reg <= scroll_cnt_reg + 64'd1;
                        // with one row only the blank pass runs, on row 0
                        sw_addr_reg  <= (act_rows > 5'd1) ? AW1'(MAX_COLUMNS) : '0;
                        row_base_reg <= AW1'(MAX_COLUMNS);
                        sw_col_reg   <= 7'd0;
                        sw_row_reg   <= 5'd1;
                    end else begin
                        sw_addr_reg <= '0;
                    end
                end
                ST_COPY: begin
                    cp_pend_reg  <= 1'b1;
                    cp_waddr_reg <= sw_addr_reg - AW1'(MAX_COLUMNS);
                    if (copy_last) begin
                        // bottom row is the one just read from
                        sw_addr_reg <= row_base_reg;
                        sw_col_reg  <= 7'd0;
                    end else if (copy_row_end) begin
                        sw_col_reg   <= 7'd0;
                        sw_row_reg   <= sw_row_reg + 5'd1;
                        row_base_reg <= row_base_reg + AW1'(MAX_COLUMNS);
                        sw_addr_reg  <= row_base_reg + AW1'(MAX_COLUMNS);
                    end else begin
                        sw_col_reg  <= sw_col_reg + 7'd1;
                        sw_addr_reg <= sw_addr_reg + AW1'(1);
                    end
                end
                ST_BLANK: begin
                    if (!cp_pend_reg) begin
                        sw_col_reg  <= sw_col_reg + 7'd1;
                        sw_addr_reg <= sw_addr_reg + AW1'(1);
                    end
                end
                ST_IDLE, ST_DONE: begin
                end
                default: begin
                end
            endcase
        end
    end

    // captured item and result flags
    always_ff @(posedge aclk) begin
        if (s_fire) begin
            op_reg <= op_t'(s_tuser[1:0]);
            ch_reg <= s_tdata[7:0];
            tc_reg <= s_tdata[14:8];
            tr_reg <= s_tdata[19:15];
        end
        if (state_reg == ST_EXEC) begin
            res_err_reg <= ex_err;
            res_rd_reg  <= ex_rd;
        end
    end

    // ------------------------------------------------------------------
    // result register
    // ------------------------------------------------------------------
    logic        out_load;
    logic [7:0]  res_char, res_attr;

    assign out_load = (state_reg == ST_DONE) && out_free;
    assign res_char = res_rd_reg ? mem_rd_data[7:0]  : 8'd0;
    assign res_attr = res_rd_reg ? mem_rd_data[15:8] : 8'd0;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (out_load) begin
            m_tvalid_reg <= 1'b1;
        end else if (m_tready) begin
            m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (out_load) begin
            m_tdata_reg <= {3'd0, res_err_reg, scroll_cnt_reg, cur_row_reg, cur_col_reg,
                            res_attr, res_char};
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    // ------------------------------------------------------------------
    // config port
    // ------------------------------------------------------------------
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_cols_reg <= RESET_COLS;
            cfg_rows_reg <= RESET_ROWS;
            cfg_attr_reg <= RESET_ATTR;
        end else if (cfg_wr) begin
            unique case (paddr[3:2])
                REG_COLS: cfg_cols_reg <= pwdata[6:0];
                REG_ROWS: cfg_rows_reg <= pwdata[4:0];
                REG_ATTR: cfg_attr_reg <= pwdata[7:0];
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        unique case (paddr[3:2])
            REG_COLS: prdata = {25'd0, cfg_cols_reg};
            REG_ROWS: prdata = {27'd0, cfg_rows_reg};
            REG_ATTR: prdata = {24'd0, cfg_attr_reg};
            default:  prdata = 32'd0;
        endcase
    end

    // ------------------------------------------------------------------
    // assertions
    // ------------------------------------------------------------------
`ifndef SYNTHESIS
    a_cursor_in_area: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_DONE) |-> (cur_col_reg < act_cols) && (cur_row_reg < act_rows))
        else $error("cursor outside active area at result stage");

    a_no_accept_in_sweep: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_INIT || state_reg == ST_CLEAR || state_reg == ST_COPY ||
         state_reg == ST_BLANK) |-> !s_tready)
        else $error("item accepted during a memory walk");

    a_copy_pend_scope: assert property (@(posedge aclk) disable iff (!aresetn)
        cp_pend_reg |-> (state_reg == ST_COPY || state_reg == ST_BLANK))
        else $error("copy write-back pending outside scroll");

    a_scroll_only_exec: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg != ST_EXEC) |=> $stable(scroll_cnt_reg))
        else $error("scroll count moved outside execute");
`endif

endmodule
